// ===== design/npc_pkg.sv =====
// constants, types and palette table for the nearest palette color core
// no dependencies; used by the interfaces and the core
package npc_pkg;

  localparam int PaletteSize = 26;
  localparam int ChanW       = 8;
  localparam int ColorW      = 3 * ChanW;
  localparam int IdxW        = 5;
  localparam int DistW       = 18;
  localparam int GroupSize   = 8;
  localparam int NumGroups   = (PaletteSize + GroupSize - 1) / GroupSize;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [ColorW-1:0] color_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [DistW-1:0]  dist_t;

  typedef struct packed {
    dist_t distance;
    idx_t  idx;
  } cand_t;

  function automatic color_t palette_color(idx_t idx);
    color_t c;
    unique case (idx)
      5'd0:    c = 24'hF5E0DC;
      5'd1:    c = 24'hF2CDCD;
      5'd2:    c = 24'hF5C2E7;
      5'd3:    c = 24'hCBA6F7;
      5'd4:    c = 24'hF38BA8;
      5'd5:    c = 24'hEBA0AC;
      5'd6:    c = 24'hFAB387;
      5'd7:    c = 24'hF9E2AF;
      5'd8:    c = 24'hA6E3A1;
      5'd9:    c = 24'h94E2D5;
      5'd10:   c = 24'h89DCEB;
      5'd11:   c = 24'h74C7EC;
      5'd12:   c = 24'h89B4FA;
      5'd13:   c = 24'hB4BEFE;
      5'd14:   c = 24'hCDD6F4;
      5'd15:   c = 24'hBAC2DE;
      5'd16:   c = 24'hA6ADC8;
      5'd17:   c = 24'h9399B2;
      5'd18:   c = 24'h7F849C;
      5'd19:   c = 24'h6C7086;
      5'd20:   c = 24'h585B70;
      5'd21:   c = 24'h45475A;
      5'd22:   c = 24'h313244;
      5'd23:   c = 24'h1E1E2E;
      5'd24:   c = 24'h181825;
      5'd25:   c = 24'h11111B;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic dist_t sq_dist(chan_t a, chan_t b);
    chan_t            d;
    logic [2*ChanW-1:0] sq;
    d  = (a >= b) ? (a - b) : (b - a);
    sq = d * d;
    return DistW'(sq);
  endfunction

endpackage

// ===== design/npc_if.sv =====
// valid/ready channel interfaces for pixel input and nearest color result
// depends on npc_pkg
interface npc_pixel_if;
  logic           valid;
  logic           ready;
  npc_pkg::chan_t pixel_red;
  npc_pkg::chan_t pixel_green;
  npc_pkg::chan_t pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface npc_near_if;
  logic           valid;
  logic           ready;
  npc_pkg::chan_t near_red;
  npc_pkg::chan_t near_green;
  npc_pkg::chan_t near_blue;
  npc_pkg::idx_t  near_index;
  npc_pkg::dist_t near_distance;

  modport source (output valid, near_red, near_green, near_blue, near_index,
                  near_distance, input ready);
  modport sink   (input valid, near_red, near_green, near_blue, near_index,
                  near_distance, output ready);
endinterface

// ===== design/nearest_palette_color_core.sv =====
// nearest palette color core: maps an rgb888 pixel to the closest entry of
// a fixed 26-color palette; depends on npc_pkg and npc_if
//
// One pixel transaction is accepted per cycle while pixel_i.ready is high
// and gives one result transaction after the input register, the
// squared-distance register with all 26 entries in parallel, the per-group
// minimum register over groups of eight entries and the result register.
// Sustained rate is one pixel per cycle while results are taken; a stage
// holds while full and the next cannot take it, so a stalled result does
// not keep earlier empty stages from filling. Ties give the lowest index.
module nearest_palette_color_core (
  input logic         clk_i,
  input logic         rst_ni,
  npc_pixel_if.sink   pixel_i,
  npc_near_if.source  near_o
);

  logic rdy0, rdy1, rdy2, rdy3;

  logic           v0_q;
  npc_pkg::chan_t r0_q, g0_q, b0_q;

  logic           v1_q;
  npc_pkg::dist_t dist_q [npc_pkg::PaletteSize];
  npc_pkg::dist_t dist_d [npc_pkg::PaletteSize];

  logic           v2_q;
  npc_pkg::cand_t grp_q  [npc_pkg::NumGroups];
  npc_pkg::cand_t grp_d  [npc_pkg::NumGroups];

  logic           v3_q;
  npc_pkg::cand_t best_d, best_q;
  npc_pkg::color_t color_q;

  assign rdy3 = !v3_q || near_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign pixel_i.ready = rdy0;

  // distances to every palette entry
  always_comb begin
    for (int i = 0; i < npc_pkg::PaletteSize; i++) begin
      npc_pkg::color_t c;
      c = npc_pkg::palette_color(npc_pkg::IdxW'(i));
      dist_d[i] = npc_pkg::sq_dist(r0_q, c[23:16])
                + npc_pkg::sq_dist(g0_q, c[15:8])
                + npc_pkg::sq_dist(b0_q, c[7:0]);
    end
  end

  // minimum within each group, strict compare keeps lower index
  always_comb begin
    for (int g = 0; g < npc_pkg::NumGroups; g++) begin
      grp_d[g].distance = dist_q[npc_pkg::IdxW'(g * npc_pkg::GroupSize)];
      grp_d[g].idx      = npc_pkg::IdxW'(g * npc_pkg::GroupSize);
      for (int k = 1; k < npc_pkg::GroupSize; k++) begin
        if (g * npc_pkg::GroupSize + k < npc_pkg::PaletteSize) begin
          if (dist_q[npc_pkg::IdxW'(g * npc_pkg::GroupSize + k)] < grp_d[g].distance) begin
            grp_d[g].distance = dist_q[npc_pkg::IdxW'(g * npc_pkg::GroupSize + k)];
            grp_d[g].idx      = npc_pkg::IdxW'(g * npc_pkg::GroupSize + k);
          end
        end
      end
    end
  end

  // minimum over the group winners
  always_comb begin
    best_d = grp_q[0];
    for (int g = 1; g < npc_pkg::NumGroups; g++) begin
      if (grp_q[g].distance < best_d.distance) begin
        best_d = grp_q[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= pixel_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && pixel_i.valid) begin
      r0_q <= pixel_i.pixel_red;
      g0_q <= pixel_i.pixel_green;
      b0_q <= pixel_i.pixel_blue;
    end
    if (rdy1 && v0_q) begin
      dist_q <= dist_d;
    end
    if (rdy2 && v1_q) begin
      grp_q <= grp_d;
    end
    if (rdy3 && v2_q) begin
      best_q  <= best_d;
      color_q <= npc_pkg::palette_color(best_d.idx);
    end
  end

  assign near_o.valid         = v3_q;
  assign near_o.near_red      = color_q[23:16];
  assign near_o.near_green    = color_q[15:8];
  assign near_o.near_blue     = color_q[7:0];
  assign near_o.near_index    = best_q.idx;
  assign near_o.near_distance = best_q.distance;

endmodule

// ===== sim/tb_nearest_palette_color_core.sv =====
// self-checking testbench for nearest_palette_color_core: random and directed pixels
// are checked against a behavioral nearest-color search over its own palette table
// depends on npc_pkg, npc_if and the core
module tb_nearest_palette_color_core;

  localparam int ResetCycles = 12;
  localparam int RandomPixels = 450;
  localparam int HoldCycles = 80;
  localparam int TailCycles = 12;

  typedef struct packed {
    npc_pkg::chan_t red;
    npc_pkg::chan_t green;
    npc_pkg::chan_t blue;
  } pixel_t;

  typedef struct packed {
    npc_pkg::chan_t red;
    npc_pkg::chan_t green;
    npc_pkg::chan_t blue;
    npc_pkg::idx_t  index;
    npc_pkg::dist_t distance;
  } near_color_t;

  typedef enum logic [1:0] {
    RxAlways,
    RxCoinFlip,
    RxMostly,
    RxPeriodic
  } rx_mode_e;

  logic clk;
  logic rst_n;

  npc_pixel_if pixel_if ();
  npc_near_if  near_if ();

  nearest_palette_color_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pixel_i(pixel_if),
    .near_o (near_if)
  );

  npc_pkg::color_t swatches [npc_pkg::PaletteSize] = '{
    24'hF5E0DC, 24'hF2CDCD, 24'hF5C2E7, 24'hCBA6F7, 24'hF38BA8, 24'hEBA0AC,
    24'hFAB387, 24'hF9E2AF, 24'hA6E3A1, 24'h94E2D5, 24'h89DCEB, 24'h74C7EC,
    24'h89B4FA, 24'hB4BEFE, 24'hCDD6F4, 24'hBAC2DE, 24'hA6ADC8, 24'h9399B2,
    24'h7F849C, 24'h6C7086, 24'h585B70, 24'h45475A, 24'h313244, 24'h1E1E2E,
    24'h181825, 24'h11111B
  };

  pixel_t      pixel_queue [$];
  near_color_t expected_colors [$];

  int       fail_count = 0;
  int       pixels_taken = 0;
  bit       pixel_fired = 1'b0;
  bit       hold_off = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       rx_cycle = 0;
  rx_mode_e rx_mode = RxAlways;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // search with strict compare, so the lowest index survives a tie
  function automatic near_color_t nearest_color(pixel_t px);
    near_color_t     best;
    int              best_dist;
    int              cur_dist;
    int              dr;
    int              dg;
    int              db;
    npc_pkg::color_t c;
    best = '0;
    best_dist = 0;
    for (int i = 0; i < npc_pkg::PaletteSize; i++) begin
      c = swatches[i];
      dr = int'(px.red) - int'(c[23:16]);
      dg = int'(px.green) - int'(c[15:8]);
      db = int'(px.blue) - int'(c[7:0]);
      cur_dist = dr * dr + dg * dg + db * db;
      if (i == 0 || cur_dist < best_dist) begin
        best_dist = cur_dist;
        best.red = c[23:16];
        best.green = c[15:8];
        best.blue = c[7:0];
        best.index = npc_pkg::idx_t'(i);
      end
    end
    best.distance = npc_pkg::dist_t'(best_dist);
    return best;
  endfunction

  function automatic npc_pkg::chan_t jitter(npc_pkg::chan_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return npc_pkg::chan_t'(v);
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_t px;
    px.red = npc_pkg::chan_t'(r);
    px.green = npc_pkg::chan_t'(g);
    px.blue = npc_pkg::chan_t'(b);
    pixel_queue.push_back(px);
  endtask

  task automatic check_field(string field, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    near_color_t exp_color;
    pixel_t      px;
    pixel_fired = 1'b0;
    if (rst_n) begin
      if (pixel_if.valid && pixel_if.ready) begin
        px.red = pixel_if.pixel_red;
        px.green = pixel_if.pixel_green;
        px.blue = pixel_if.pixel_blue;
        expected_colors.push_back(nearest_color(px));
        pixels_taken++;
        pixel_fired = 1'b1;
      end
      if (near_if.valid && near_if.ready) begin
        if (expected_colors.size() == 0) begin
          $error("result transaction with no pixel pending");
          fail_count++;
        end else begin
          exp_color = expected_colors.pop_front();
          check_field("near_red", exp_color.red, near_if.near_red);
          check_field("near_green", exp_color.green, near_if.near_green);
          check_field("near_blue", exp_color.blue, near_if.near_blue);
          check_field("near_index", exp_color.index, near_if.near_index);
          check_field("near_distance", exp_color.distance, near_if.near_distance);
        end
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin : drive_pixels
    pixel_t px;
    if (rst_n && !(pixel_if.valid && !pixel_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_if.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        px = pixel_queue.pop_front();
        pixel_if.valid <= 1'b1;
        pixel_if.pixel_red <= px.red;
        pixel_if.pixel_green <= px.green;
        pixel_if.pixel_blue <= px.blue;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        pixel_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is redrawn at random from four modes
  always @(negedge clk) begin : drive_ready
    bit rdy;
    rx_cycle++;
    if (rx_cycle % 96 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RxAlways:   rdy = 1'b1;
      RxCoinFlip: rdy = $urandom_range(0, 1);
      RxMostly:   rdy = ($urandom_range(0, 4) != 0);
      default:    rdy = ((rx_cycle % 7) >= 3);
    endcase
    near_if.ready <= rst_n && !hold_off && rdy;
  end

  // long receiver hold-offs so the pipeline fills and backpressures the input
  initial begin
    wait (pixels_taken >= 60);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off = 1'b0;
    wait (pixels_taken >= 260);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    pixel_t          px;
    npc_pkg::color_t c;
    int              pick;
    pixel_if.valid = 1'b0;
    pixel_if.pixel_red = '0;
    pixel_if.pixel_green = '0;
    pixel_if.pixel_blue = '0;
    near_if.ready = 1'b0;
    rst_n = 1'b0;

    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(8'hAA, 8'h55, 8'hAA);
    add_pixel(8'h55, 8'hAA, 8'h55);
    // exact palette hits at both ends and the middle
    add_pixel(8'hF5, 8'hE0, 8'hDC);
    add_pixel(8'h89, 8'hB4, 8'hFA);
    add_pixel(8'h11, 8'h11, 8'h1B);
    // first two equidistant from entries 24 and 25, lower index must win
    add_pixel(15, 16, 39);
    add_pixel(20, 21, 32);
    add_pixel(1, 128, 254);

    for (int n = 0; n < RandomPixels; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        px = pixel_t'($urandom);
      end else begin
        c = swatches[$urandom_range(0, npc_pkg::PaletteSize - 1)];
        pick = (pick == 9) ? 0 : ((pick == 8) ? 3 : 12);
        px.red = jitter(c[23:16], pick);
        px.green = jitter(c[15:8], pick);
        px.blue = jitter(c[7:0], pick);
      end
      pixel_queue.push_back(px);
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pixel_queue.size() != 0 || pixel_if.valid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (expected_colors.size() != 0) begin
      $error("%0d expected results never arrived", expected_colors.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_nearest_palette_color_core OK");
    end else begin
      $display("tb_nearest_palette_color_core NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_nearest_palette_color_core NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
design/npc_pkg.sv
design/npc_if.sv
design/nearest_palette_color_core.sv
sim/tb_nearest_palette_color_core.sv
